@@ hw/rtl/quadrilateral_pixel_mask_macros.svh @@
// Assertion macros for the quadrilateral pixel mask.
// Expects clk and arst_n in the scope of each use.
`ifndef QUADRILATERAL_PIXEL_MASK_MACROS_SVH
`define QUADRILATERAL_PIXEL_MASK_MACROS_SVH

// same-cycle implication
`define QPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/qpm_pkg.sv @@
// Shared types and constants for the quadrilateral pixel mask.
// No dependencies.
package qpm_pkg;

	localparam int PIX_W = 16;
	localparam int CRN_W = 20;
	localparam int DIF_W = 21;
	localparam int PRD_W = 42;
	localparam int NUM_W = 43;
	localparam int N3_W  = 45;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic       inside_res;
		logic [1:0] which_triangle;
	} res_t;

	typedef struct packed {
		logic signed [CRN_W-1:0] x;
		logic signed [CRN_W-1:0] y;
	} corner_t;

	typedef struct packed {
		corner_t a;
		corner_t b;
		corner_t c;
		corner_t d;
	} corners_t;

	typedef enum logic [2:0] {
		REG_AX = 3'd0,
		REG_AY = 3'd1,
		REG_BX = 3'd2,
		REG_BY = 3'd3,
		REG_CX = 3'd4,
		REG_CY = 3'd5,
		REG_DX = 3'd6,
		REG_DY = 3'd7
	} reg_idx_t;

	localparam logic [1:0] TRI_NONE = 2'd0;
	localparam logic [1:0] TRI_ABC  = 2'd1;
	localparam logic [1:0] TRI_ACD  = 2'd2;

endpackage

@@ hw/rtl/qpm_regs.sv @@
// APB corner register file for the quadrilateral pixel mask.
// Depends on qpm_pkg.
module qpm_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output qpm_pkg::corners_t corners
);
	import qpm_pkg::*;

	corners_t crn_q;
	reg_idx_t idx;
	logic     wr;
	logic signed [CRN_W-1:0] wval;
	logic signed [CRN_W-1:0] rval;

	assign idx     = reg_idx_t'(paddr[4:2]);
	assign wr      = psel & penable & pwrite;
	assign wval    = pwdata[CRN_W-1:0];
	assign pready  = 1'b1;
	assign corners = crn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crn_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_AX: crn_q.a.x <= wval;
				REG_AY: crn_q.a.y <= wval;
				REG_BX: crn_q.b.x <= wval;
				REG_BY: crn_q.b.y <= wval;
				REG_CX: crn_q.c.x <= wval;
				REG_CY: crn_q.c.y <= wval;
				REG_DX: crn_q.d.x <= wval;
				REG_DY: crn_q.d.y <= wval;
				default: crn_q <= crn_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_AX:  rval = crn_q.a.x;
			REG_AY:  rval = crn_q.a.y;
			REG_BX:  rval = crn_q.b.x;
			REG_BY:  rval = crn_q.b.y;
			REG_CX:  rval = crn_q.c.x;
			REG_CY:  rval = crn_q.c.y;
			REG_DX:  rval = crn_q.d.x;
			REG_DY:  rval = crn_q.d.y;
			default: rval = '0;
		endcase
		prdata = 32'(rval);
	end

endmodule

@@ hw/rtl/qpm_tri.sv @@
// Four-stage barycentric triangle test against vertices v0, v1, v2.
// Depends on qpm_pkg.
module qpm_tri (
	input  logic             clk,
	input  logic             adv,
	input  qpm_pkg::corner_t v0,
	input  qpm_pkg::corner_t v1,
	input  qpm_pkg::corner_t v2,
	input  qpm_pkg::pix_t    pix,
	output logic             hit
);
	import qpm_pkg::*;

	function automatic logic in_rng(input logic signed [N3_W-1:0] n,
			input logic signed [N3_W-1:0] det);
		logic r;
		if (det > 0)
			r = (n >= 0) && (n <= det);
		else
			r = (n <= 0) && (n >= det);
		return r;
	endfunction

	logic signed [CRN_W-1:0] px, py;
	logic signed [DIF_W-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1;
	logic signed [PRD_W-1:0] ab_s2, cd_s2, be_s2, cf_s2, af_s2, de_s2;
	logic signed [NUM_W-1:0] det_s3, n1_s3, n2_s3;
	logic signed [N3_W-1:0]  det_s4, n3_s4;
	logic                    nz_s4, ok1_s4, ok2_s4;

	assign px = {pix.pixel_x, 4'b0000};
	assign py = {pix.pixel_y, 4'b0000};

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= DIF_W'(v0.x) - DIF_W'(v2.x);
			b_s1 <= DIF_W'(v1.y) - DIF_W'(v2.y);
			c_s1 <= DIF_W'(v1.x) - DIF_W'(v2.x);
			d_s1 <= DIF_W'(v0.y) - DIF_W'(v2.y);
			e_s1 <= DIF_W'(px) - DIF_W'(v2.x);
			f_s1 <= DIF_W'(py) - DIF_W'(v2.y);

			ab_s2 <= a_s1 * b_s1;
			cd_s2 <= c_s1 * d_s1;
			be_s2 <= b_s1 * e_s1;
			cf_s2 <= c_s1 * f_s1;
			af_s2 <= a_s1 * f_s1;
			de_s2 <= d_s1 * e_s1;

			det_s3 <= NUM_W'(ab_s2) - NUM_W'(cd_s2);
			n1_s3  <= NUM_W'(be_s2) - NUM_W'(cf_s2);
			n2_s3  <= NUM_W'(af_s2) - NUM_W'(de_s2);

			det_s4 <= N3_W'(det_s3);
			n3_s4  <= N3_W'(det_s3) - N3_W'(n1_s3) - N3_W'(n2_s3);
			nz_s4  <= det_s3 != '0;
			ok1_s4 <= in_rng(N3_W'(n1_s3), N3_W'(det_s3));
			ok2_s4 <= in_rng(N3_W'(n2_s3), N3_W'(det_s3));
		end
	end

	assign hit = nz_s4 & ok1_s4 & ok2_s4 & in_rng(n3_s4, det_s4);

endmodule

@@ hw/rtl/qpm_outbuf.sv @@
// Output register with one skid entry for the quadrilateral pixel mask.
// Depends on qpm_pkg and the assertion macro header.
module qpm_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  qpm_pkg::res_t push_data,
	output logic          full,
	output logic          res_valid,
	input  logic          res_ready,
	output qpm_pkg::res_t res
);
	import qpm_pkg::*;
	`include "quadrilateral_pixel_mask_macros.svh"

	logic out_vld_q, skd_vld_q;
	res_t out_q, skd_q;
	logic free;

	assign free      = !out_vld_q || res_ready;
	assign full      = skd_vld_q;
	assign res_valid = out_vld_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (free) begin
			out_vld_q <= skd_vld_q || push;
			skd_vld_q <= 1'b0;
		end else if (push) begin
			skd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free)
			out_q <= skd_vld_q ? skd_q : push_data;
		else if (push)
			skd_q <= push_data;
	end

	`QPM_ASSERT_IMP(a_skd_needs_out, skd_vld_q, out_vld_q, "skid holds data with empty output")
	`QPM_ASSERT_IMP(a_no_push_full, skd_vld_q, !push, "push while skid entry full")
	`QPM_ASSERT_NXT(a_stall_fill, out_vld_q && !res_ready && push, skd_vld_q,
		"stalled transaction not captured in skid")

endmodule

@@ hw/rtl/quadrilateral_pixel_mask.sv @@
// Top level of the quadrilateral pixel mask: corner registers, two triangle pipes, output buffer.
// Depends on qpm_pkg, qpm_regs, qpm_tri, qpm_outbuf and the assertion macro header.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  cfg     | psel/penable/pready  | paddr, pwdata, prdata
//  pix     | pix_valid/pix_ready  | pix (pixel_x, pixel_y)
//  res     | res_valid/res_ready  | res (inside_res, which_triangle)
//
// One pixel per clock while pix_ready is high.
// A result passes through four pipeline stages (difference, multiply, sum, n3 and range) plus output register.
// Reset clears the corner registers, the valid bits and the output buffer.
// A stall on res fills the skid entry; pix_ready then drops and the pipeline holds.
module quadrilateral_pixel_mask (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  qpm_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_ready,
	output qpm_pkg::res_t res
);
	import qpm_pkg::*;
	`include "quadrilateral_pixel_mask_macros.svh"

	corners_t corners;
	logic     adv, full;
	logic     vld_s1, vld_s2, vld_s3, vld_s4;
	logic     hit_abc, hit_acd;
	res_t     pres;

	qpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.corners (corners)
	);

	assign adv       = !full;
	assign pix_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	qpm_tri u_tri_abc (
		.clk (clk),
		.adv (adv),
		.v0  (corners.a),
		.v1  (corners.b),
		.v2  (corners.c),
		.pix (pix),
		.hit (hit_abc)
	);

	qpm_tri u_tri_acd (
		.clk (clk),
		.adv (adv),
		.v0  (corners.a),
		.v1  (corners.c),
		.v2  (corners.d),
		.pix (pix),
		.hit (hit_acd)
	);

	always_comb begin
		pres.inside_res = hit_abc | hit_acd;
		if (hit_abc)
			pres.which_triangle = TRI_ABC;
		else if (hit_acd)
			pres.which_triangle = TRI_ACD;
		else
			pres.which_triangle = TRI_NONE;
	end

	qpm_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s4 & adv),
		.push_data (pres),
		.full      (full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	`QPM_ASSERT_IMP(a_res_consistent, res_valid,
		(res.inside_res == (res.which_triangle != TRI_NONE)) && (res.which_triangle != 2'd3),
		"inside flag disagrees with triangle code")
	`QPM_ASSERT_NXT(a_hold_on_stall, !adv,
		$stable({vld_s1, vld_s2, vld_s3, vld_s4}), "pipeline moved while stalled")
	`QPM_ASSERT_IMP(a_entry_from_accept, $rose(vld_s1), $past(pix_valid && pix_ready),
		"stage one valid without accepted transaction")

endmodule
